// ===== design/fdl_pkg.sv =====
`default_nettype none

package fdl_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int FRAC_W        = 8;
	localparam int MAX_DELAY_DEF = 4095;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// per-item control that travels alongside the two memory reads
	typedef struct packed {
		logic [FRAC_W-1:0] frac;
		logic              fwd_a;
		logic              fwd_b;
		logic              clr_a;
		logic              clr_b;
		sample_t           wdata;
	} rd_ctl_t;

endpackage

`default_nettype wire

// ===== design/fdl_in_if.sv =====
`default_nettype none

interface fdl_in_if;
	logic            valid;
	logic            ready;
	fdl_pkg::sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== design/fdl_out_if.sv =====
`default_nettype none

interface fdl_out_if;
	logic            valid;
	logic            ready;
	fdl_pkg::sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== design/fdl_ram.sv =====
`default_nettype none

module fdl_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/fdl_addr.sv =====
`default_nettype none

module fdl_addr #(
	parameter int MAX_DELAY = fdl_pkg::MAX_DELAY_DEF,
	parameter int AW        = $clog2(MAX_DELAY + 1),
	parameter int DW        = AW + fdl_pkg::FRAC_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              xfer,
	input  wire fdl_pkg::sample_t  sample_in,
	input  wire logic [DW-1:0]     delay,
	output logic      [AW-1:0]     wr_addr,
	output logic      [AW-1:0]     rd_addr_a,
	output logic      [AW-1:0]     rd_addr_b,
	output fdl_pkg::rd_ctl_t       ctl_s1
);

	localparam int            PW     = DW + 1;
	localparam logic [PW-1:0] LEN_Q8 = PW'(MAX_DELAY + 1) << fdl_pkg::FRAC_W;
	localparam logic [AW-1:0] LAST   = AW'(MAX_DELAY);

	logic [AW-1:0]     wp_q;
	logic              full_q;
	logic [PW-1:0]     wp_q8;
	logic [PW-1:0]     pos_raw;
	logic [PW-1:0]     pos_wrap;
	logic [PW-1:0]     pos;
	logic [AW-1:0]     ipart;
	logic [AW-1:0]     inext;
	fdl_pkg::rd_ctl_t  ctl;

	assign wp_q8    = {1'b0, wp_q, {fdl_pkg::FRAC_W{1'b0}}};
	// both candidates in parallel, the sign of the plain difference picks
	assign pos_raw  = wp_q8 - {1'b0, delay};
	assign pos_wrap = wp_q8 + LEN_Q8 - {1'b0, delay};
	assign pos      = pos_raw[PW-1] ? pos_wrap : pos_raw;
	assign ipart    = pos[DW-1:fdl_pkg::FRAC_W];
	assign inext    = (ipart == LAST) ? '0 : ipart + 1'b1;

	assign wr_addr   = wp_q;
	assign rd_addr_a = ipart;
	assign rd_addr_b = inext;

	// entries above the write pointer are unwritten until the first wrap
	always_comb begin
		ctl.frac  = pos[fdl_pkg::FRAC_W-1:0];
		ctl.fwd_a = (ipart == wp_q);
		ctl.fwd_b = (inext == wp_q);
		ctl.clr_a = !full_q && (ipart > wp_q);
		ctl.clr_b = !full_q && (inext > wp_q);
		ctl.wdata = sample_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (xfer) begin
			if (wp_q == LAST) begin
				wp_q   <= '0;
				full_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			ctl_s1 <= ctl;
		end
	end

endmodule

`default_nettype wire

// ===== design/fdl_interp.sv =====
`default_nettype none

module fdl_interp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              xfer,
	input  wire fdl_pkg::rd_ctl_t  ctl_s1,
	input  wire fdl_pkg::sample_t  rdata_a,
	input  wire fdl_pkg::sample_t  rdata_b,
	output logic                   out_valid,
	output fdl_pkg::sample_t       out_sample
);

	localparam int DIFF_W = fdl_pkg::SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + fdl_pkg::FRAC_W + 1;
	localparam int ACC_W  = PROD_W + 1;

	logic                     v_s1;
	logic                     v_s2;
	logic                     out_valid_q;
	fdl_pkg::sample_t         a;
	fdl_pkg::sample_t         b;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	fdl_pkg::sample_t         a_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  rnd;
	fdl_pkg::sample_t         res;
	fdl_pkg::sample_t         out_sample_q;

	// same-cycle write wins over the stale memory word
	always_comb begin
		priority if (ctl_s1.fwd_a) a = ctl_s1.wdata;
		else if (ctl_s1.clr_a)     a = '0;
		else                       a = rdata_a;
		priority if (ctl_s1.fwd_b) b = ctl_s1.wdata;
		else if (ctl_s1.clr_b)     b = '0;
		else                       b = rdata_b;
	end

	assign diff = DIFF_W'(b) - DIFF_W'(a);
	assign prod = PROD_W'(diff * $signed({1'b0, ctl_s1.frac}));

	// round half up, then clamp to full scale
	assign acc = (ACC_W'(a_s2) <<< fdl_pkg::FRAC_W) + ACC_W'(prod_s2)
		+ ACC_W'(128);
	assign rnd = acc >>> fdl_pkg::FRAC_W;

	always_comb begin
		priority if (rnd > ACC_W'(32767))   res = 16'sh7fff;
		else if (rnd < -ACC_W'(32768))      res = 16'sh8000;
		else                                res = rnd[fdl_pkg::SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= xfer;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2         <= a;
			prod_s2      <= prod;
			out_sample_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

endmodule

`default_nettype wire

// ===== design/fractional_delay_line.sv =====
// Fractional delay line with linear interpolation.
// in_ch carries one signed Q1.15 sample per transfer; each transfer yields
// exactly one interpolated sample on out_ch, in order.
// The delay (samples, 8 fraction bits) is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle; the block itself
// does not enforce this. A value above MAX_DELAY*256 is dropped.
// Throughput: one sample per cycle, except while a blocked result stalls the
// pipeline. Each sample does one write and two reads in the same cycle,
// served by two copies of the sample store with one write and one read port
// each; the pipeline is memory read, multiply, round/saturate.
// Reset: write pointer to zero, delay to MAX_DELAY*256, and the store reads
// as zero; entries not yet written since reset are masked by a fill marker,
// so no clearing pass is needed and in_ch.ready is high right after reset.
// Stall: while a result waits on out_ch and the receiver is not ready the
// whole pipeline holds and in_ch.ready is low; otherwise a new input is
// taken in the same cycle that the waiting result is taken.
`default_nettype none

module fractional_delay_line #(
	parameter int MAX_DELAY = fdl_pkg::MAX_DELAY_DEF,
	parameter int AW        = $clog2(MAX_DELAY + 1),
	parameter int DW        = AW + fdl_pkg::FRAC_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	fdl_in_if.sink             in_ch,
	fdl_out_if.source          out_ch,
	input  wire logic          cfg_we,
	input  wire logic [DW-1:0] cfg_wdata
);

	localparam logic [DW-1:0] DELAY_LIMIT = DW'(MAX_DELAY) << fdl_pkg::FRAC_W;

	logic              adv;
	logic              xfer;
	logic [DW-1:0]     delay_q;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;
	fdl_pkg::rd_ctl_t  ctl_s1;
	fdl_pkg::sample_t  rdata_a;
	fdl_pkg::sample_t  rdata_b;
	logic              out_valid;
	fdl_pkg::sample_t  out_sample;

	assign adv         = !(out_valid && !out_ch.ready);
	assign in_ch.ready = adv;
	assign xfer        = in_ch.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_LIMIT;
		end else if (cfg_we && (cfg_wdata <= DELAY_LIMIT)) begin
			delay_q <= cfg_wdata;
		end
	end

	fdl_addr #(
		.MAX_DELAY (MAX_DELAY),
		.AW        (AW),
		.DW        (DW)
	) u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.xfer      (xfer),
		.sample_in (in_ch.sample_in),
		.delay     (delay_q),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.ctl_s1    (ctl_s1)
	);

	fdl_ram #(
		.W     (fdl_pkg::SAMPLE_W),
		.DEPTH (MAX_DELAY + 1)
	) u_ram_a (
		.clk   (clk),
		.we    (xfer),
		.waddr (wr_addr),
		.wdata (in_ch.sample_in),
		.re    (xfer),
		.raddr (rd_addr_a),
		.rdata (rdata_a)
	);

	fdl_ram #(
		.W     (fdl_pkg::SAMPLE_W),
		.DEPTH (MAX_DELAY + 1)
	) u_ram_b (
		.clk   (clk),
		.we    (xfer),
		.waddr (wr_addr),
		.wdata (in_ch.sample_in),
		.re    (xfer),
		.raddr (rd_addr_b),
		.rdata (rdata_b)
	);

	fdl_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.xfer       (xfer),
		.ctl_s1     (ctl_s1),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b),
		.out_valid  (out_valid),
		.out_sample (out_sample)
	);

	assign out_ch.valid      = out_valid;
	assign out_ch.sample_out = out_sample;

	// input is refused only while a finished result is blocked
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (out_ch.valid && !out_ch.ready))
		else $error("input stalled without a blocked result");

	a_delay_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		delay_q <= DELAY_LIMIT)
		else $error("delay register above limit");

	a_read_addr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> (rd_addr_a <= AW'(MAX_DELAY)) && (rd_addr_b <= AW'(MAX_DELAY)))
		else $error("read address outside the sample store");

	a_next_follows: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> (rd_addr_b == ((rd_addr_a == AW'(MAX_DELAY)) ? '0 : rd_addr_a + 1'b1)))
		else $error("partner read address is not the next entry");

endmodule

`default_nettype wire
